// ===== rtl/ccas_pkg.sv =====
// Package for the cooler condensate alarm supervisor.
// Holds the beat types, register indexes and reset values used by the register file, step logic and top level.
// Depends on nothing.
package ccas_pkg;

    localparam int unsigned DEFAULT_TIME_WIDTH = 32;
    localparam int unsigned CFG_INDEX_WIDTH    = 3;
    localparam int unsigned TEMP_WIDTH         = 16;
    localparam int unsigned THRESH_WIDTH       = 12;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_POLL_INTERVAL   = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WATER_FULL_LIM  = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OFFLINE_LIM     = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OFF_DURATION    = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TEMP_DROP_THR   = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TOGGLE_CODE     = 3'd5;

    localparam logic [31:0]             RST_POLL_INTERVAL  = 32'd2000;
    localparam logic [31:0]             RST_WATER_FULL_LIM = 32'd60000;
    localparam logic [31:0]             RST_OFFLINE_LIM    = 32'd30000;
    localparam logic [31:0]             RST_OFF_DURATION   = 32'd5000;
    localparam logic [THRESH_WIDTH-1:0] RST_TEMP_DROP_THR  = 12'd48;
    localparam logic [31:0]             RST_TOGGLE_CODE    = 32'hFF00E710;

    typedef struct packed {
        logic                          cmd;
        logic [31:0]                   now_ms;
        logic                          tank_full;
        logic                          sample_valid;
        logic signed [TEMP_WIDTH-1:0]  temp_before;
        logic signed [TEMP_WIDTH-1:0]  temp_after;
        logic [31:0]                   user_code;
    } item_t;

    typedef struct packed {
        logic        ir_send;
        logic [31:0] ir_code;
        logic        alarm_start;
        logic        alarm_stop;
        logic        sensor_power_off;
        logic        sensor_power_on;
        logic        auto_toggle_locked;
        logic        alarm_active;
    } result_t;

    typedef struct packed {
        logic [CFG_INDEX_WIDTH-1:0] index;
        logic [31:0]                data;
    } cfg_beat_t;

    typedef struct packed {
        logic [31:0]             poll_interval_ms;
        logic [31:0]             water_full_limit_ms;
        logic [31:0]             sensor_offline_limit_ms;
        logic [31:0]             sensor_off_duration_ms;
        logic [THRESH_WIDTH-1:0] temp_drop_threshold;
        logic [31:0]             toggle_code;
    } cfg_t;

endpackage

// ===== rtl/ccas_stream_if.sv =====
// Valid/ready channel interface used for the item, result and configuration channels.
// The payload type is a parameter; the concrete types come from ccas_pkg.
interface ccas_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/ccas_cfg_regs.sv =====
// Configuration register file of the condensate alarm supervisor.
// Depends on ccas_pkg for the register indexes and reset values.
module ccas_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  ccas_pkg::cfg_beat_t wr_beat,
    output ccas_pkg::cfg_t      cfg
);
    import ccas_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes to indexes beyond the list are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_beat.index)
                CFG_POLL_INTERVAL:  cfg_next.poll_interval_ms        = wr_beat.data;
                CFG_WATER_FULL_LIM: cfg_next.water_full_limit_ms     = wr_beat.data;
                CFG_OFFLINE_LIM:    cfg_next.sensor_offline_limit_ms = wr_beat.data;
                CFG_OFF_DURATION:   cfg_next.sensor_off_duration_ms  = wr_beat.data;
                CFG_TEMP_DROP_THR:  cfg_next.temp_drop_threshold     =
                                        wr_beat.data[THRESH_WIDTH-1:0];
                CFG_TOGGLE_CODE:    cfg_next.toggle_code             = wr_beat.data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poll_interval_ms        <= RST_POLL_INTERVAL;
            cfg_reg.water_full_limit_ms     <= RST_WATER_FULL_LIM;
            cfg_reg.sensor_offline_limit_ms <= RST_OFFLINE_LIM;
            cfg_reg.sensor_off_duration_ms  <= RST_OFF_DURATION;
            cfg_reg.temp_drop_threshold     <= RST_TEMP_DROP_THR;
            cfg_reg.toggle_code             <= RST_TOGGLE_CODE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/ccas_ctrl.sv =====
// Supervisor state and the single-pass step logic that turns one item into one result.
// Depends on ccas_pkg for the item, result and configuration types.
module ccas_ctrl #(
    parameter int unsigned TIME_WIDTH = ccas_pkg::DEFAULT_TIME_WIDTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  ccas_pkg::item_t   item,
    input  ccas_pkg::cfg_t    cfg,
    output ccas_pkg::result_t res
);
    import ccas_pkg::*;

    localparam int unsigned CMP_WIDTH  = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;
    localparam int unsigned DROP_WIDTH = TEMP_WIDTH + 2;

    logic [TIME_WIDTH-1:0] ltnf_reg, ltnf_next;
    logic [TIME_WIDTH-1:0] lpt_reg, lpt_next;
    logic [TIME_WIDTH-1:0] lsg_reg, lsg_next;
    logic [TIME_WIDTH-1:0] rst_time_reg, rst_time_next;
    logic signed [TEMP_WIDTH-1:0] hb_reg, hb_next;
    logic signed [TEMP_WIDTH-1:0] ha_reg, ha_next;
    logic alarm_reg, alarm_next;
    logic resetting_reg, resetting_next;
    logic poll_failed_reg, poll_failed_next;
    logic lock_reg, lock_next;

    logic [TIME_WIDTH-1:0]        now_t;
    logic signed [DROP_WIDTH-1:0] drop;
    logic signed [DROP_WIDTH-1:0] thresh;

    // Wrapping elapsed time, then a strict compare against a 32-bit limit.
    function automatic logic past_limit(
        input logic [TIME_WIDTH-1:0] now_v,
        input logic [TIME_WIDTH-1:0] then_v,
        input logic [31:0]           limit
    );
        logic [TIME_WIDTH-1:0] diff;
        diff = now_v - then_v;
        return CMP_WIDTH'(diff) > CMP_WIDTH'(limit);
    endfunction

    assign now_t  = TIME_WIDTH'(item.now_ms);
    assign drop   = DROP_WIDTH'(hb_next) - DROP_WIDTH'(ha_next);
    assign thresh = $signed({{(DROP_WIDTH-THRESH_WIDTH){1'b0}}, cfg.temp_drop_threshold});

    always_comb
    begin
        ltnf_next        = ltnf_reg;
        lpt_next         = lpt_reg;
        lsg_next         = lsg_reg;
        rst_time_next    = rst_time_reg;
        hb_next          = hb_reg;
        ha_next          = ha_reg;
        alarm_next       = alarm_reg;
        resetting_next   = resetting_reg;
        poll_failed_next = poll_failed_reg;
        lock_next        = lock_reg;
        res              = '0;

        if (item.cmd)
        begin
            if (item.user_code != 32'd0)
            begin
                if (item.user_code == cfg.toggle_code)
                begin
                    lock_next = 1'b0;
                end
                res.ir_send = 1'b1;
                res.ir_code = item.user_code;
            end
        end
        else
        begin
            if (!item.tank_full)
            begin
                ltnf_next = now_t;
                if (alarm_reg)
                begin
                    alarm_next     = 1'b0;
                    res.alarm_stop = 1'b1;
                end
            end
            if (!resetting_reg)
            begin
                if (past_limit(now_t, lpt_reg, cfg.poll_interval_ms))
                begin
                    lpt_next = now_t;
                    if (item.sample_valid)
                    begin
                        hb_next          = item.temp_before;
                        ha_next          = item.temp_after;
                        poll_failed_next = 1'b0;
                    end
                    else
                    begin
                        poll_failed_next = 1'b1;
                    end
                end
                if (!poll_failed_next)
                begin
                    lsg_next = now_t;
                    // The tank is full on this path, so its timestamp and the alarm
                    // flag are still the stored values.
                    if ((drop > thresh) && item.tank_full)
                    begin
                        if (!alarm_reg)
                        begin
                            alarm_next      = 1'b1;
                            res.alarm_start = 1'b1;
                        end
                        else if (past_limit(now_t, ltnf_reg, cfg.water_full_limit_ms))
                        begin
                            if (!lock_reg)
                            begin
                                res.ir_send = 1'b1;
                                res.ir_code = cfg.toggle_code;
                            end
                            lock_next = 1'b1;
                        end
                    end
                end
                else if (past_limit(now_t, lsg_reg, cfg.sensor_offline_limit_ms))
                begin
                    res.sensor_power_off = 1'b1;
                    resetting_next       = 1'b1;
                    rst_time_next        = now_t;
                end
            end
            else if (past_limit(now_t, rst_time_reg, cfg.sensor_off_duration_ms))
            begin
                res.sensor_power_on = 1'b1;
                resetting_next      = 1'b0;
            end
        end

        res.auto_toggle_locked = lock_next;
        res.alarm_active       = alarm_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ltnf_reg        <= '0;
            lpt_reg         <= '0;
            lsg_reg         <= '0;
            rst_time_reg    <= '0;
            hb_reg          <= '0;
            ha_reg          <= '0;
            alarm_reg       <= 1'b0;
            resetting_reg   <= 1'b0;
            poll_failed_reg <= 1'b0;
            lock_reg        <= 1'b0;
        end
        else if (step_en)
        begin
            ltnf_reg        <= ltnf_next;
            lpt_reg         <= lpt_next;
            lsg_reg         <= lsg_next;
            rst_time_reg    <= rst_time_next;
            hb_reg          <= hb_next;
            ha_reg          <= ha_next;
            alarm_reg       <= alarm_next;
            resetting_reg   <= resetting_next;
            poll_failed_reg <= poll_failed_next;
            lock_reg        <= lock_next;
        end
    end

    a_start_edge: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && res.alarm_start |=> alarm_reg && !$past(alarm_reg))
        else $error("alarm start without a rising alarm flag");

    a_power_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(res.sensor_power_off && res.sensor_power_on))
        else $error("sensor power switched off and on in one step");

    a_cmd_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && item.cmd |=> $stable(alarm_reg) && $stable(resetting_reg)
                                && $stable(lpt_reg))
        else $error("user command changed tick state");

    a_resetting_no_raise: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && resetting_reg |-> !res.alarm_start && !res.sensor_power_off)
        else $error("sampling work done while sensors are off");

endmodule

// ===== rtl/cooler_condensate_alarm_supervisor_core.sv =====
// Top level of the cooler condensate alarm supervisor.
// Depends on ccas_pkg, ccas_stream_if, ccas_cfg_regs and ccas_ctrl.
//
// Usage:
//   item   - sink channel; one beat is a periodic tick or a user infrared command.
//   result - source channel; exactly one result beat comes out for every item beat,
//            in the same order.
//   cfg    - sink channel for register writes (index, data). It is always ready,
//            and writes are meant to happen while no item is in flight.
// Each accepted item is held in an input register. When it moves on, the step
// logic computes the result and the new supervisor state in the same cycle, and
// the result lands in the output register, which presents it. The block takes one
// item per cycle as long as the receiver keeps taking results.
// The throughput is set by the single input register and single output register:
// the input register empties whenever the output register is free or its beat
// is being taken, so a new item is taken even while a result still waits.
// When the receiver stalls, the output holds its result and the input register
// fills; then item.ready drops until the receiver takes the waiting beat.
// Reset clears both register stages, the supervisor state (timestamps, held
// temperatures, alarm, sensor reset and lock flags) and loads the register
// reset values. No result is pending after reset.
module cooler_condensate_alarm_supervisor_core #(
    parameter int unsigned TIME_WIDTH = ccas_pkg::DEFAULT_TIME_WIDTH
) (
    input logic          clk,
    input logic          rst_n,
    ccas_stream_if.sink   item,
    ccas_stream_if.sink   cfg,
    ccas_stream_if.source result
);
    import ccas_pkg::*;

    logic    s1_valid_reg, s1_valid_next;
    item_t   s1_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;

    logic    item_accept;
    logic    advance;
    cfg_t    cfg_q;
    result_t step_res;

    // The stored item moves on when the output register is empty or is being drained.
    assign advance     = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready  = !s1_valid_reg || advance;
    assign item_accept = item.valid && item.ready;

    assign cfg.ready = 1'b1;

    ccas_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cfg.valid),
        .wr_beat (cfg.payload),
        .cfg     (cfg_q)
    );

    // The supervisor state only advances when its result is captured.
    ccas_ctrl #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (s1_item_reg),
        .cfg     (cfg_q),
        .res     (step_res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            s1_item_reg <= item.payload;
        end
        if (advance)
        begin
            out_res_reg <= step_res;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_res_reg;

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && !$past(item_accept))
        else $error("input register lost or overwrote a waiting item");

    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register empty after a step");

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !result.ready |-> !item.ready)
        else $error("item taken while both stages are full and stalled");

endmodule

// ===== sim/cooler_condensate_alarm_supervisor_core_tb.sv =====
// Self-checking testbench for the cooler condensate alarm supervisor core.
// Drives items and register writes over the valid/ready channels and checks each result
// against a cycle-free model of the supervisor. Depends on ccas_pkg, ccas_stream_if and the core.
module cooler_condensate_alarm_supervisor_core_tb;

    import ccas_pkg::*;

    localparam int RESET_CYCLES  = 10;
    localparam int HOLD_CYCLES   = 48;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PRINT_LIMIT   = 40;

    // First register index past the defined ones; writes there must be ignored.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_FIRST = CFG_TOGGLE_CODE + 3'd1;

    localparam result_t QUIET = '0;

    typedef struct {
        item_t   stim;
        bit      typed;
        result_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    ccas_stream_if #(.payload_t(item_t))     item_if ();
    ccas_stream_if #(.payload_t(cfg_beat_t)) cfg_if ();
    ccas_stream_if #(.payload_t(result_t))   result_if ();

    cooler_condensate_alarm_supervisor_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .cfg    (cfg_if),
        .result (result_if)
    );

    // Register copy as the block should hold it. Reset is applied once, so the
    // declaration values double as the reset state.
    cfg_t cur_cfg = '{
        poll_interval_ms:        RST_POLL_INTERVAL,
        water_full_limit_ms:     RST_WATER_FULL_LIM,
        sensor_offline_limit_ms: RST_OFFLINE_LIM,
        sensor_off_duration_ms:  RST_OFF_DURATION,
        temp_drop_threshold:     RST_TEMP_DROP_THR,
        toggle_code:             RST_TOGGLE_CODE
    };

    // Supervisor state: timestamps, held temperatures and the four flags.
    logic [31:0]            tank_clear_ms = '0;
    logic [31:0]            poll_ms       = '0;
    logic [31:0]            good_ms       = '0;
    logic [31:0]            power_off_ms  = '0;
    logic signed [15:0]     held_before   = '0;
    logic signed [15:0]     held_after    = '0;
    bit                     alarm_on      = 1'b0;
    bit                     sensors_down  = 1'b0;
    bit                     sample_stale  = 1'b0;
    bit                     toggle_lock   = 1'b0;

    // Outcomes still owed by the block, oldest first.
    result_t pending_outcomes[$];

    // Flags shared between the item driver and the result taker, then the counters.
    bit          steady    = 1'b0;
    bit          hold_req  = 1'b0;
    int unsigned error_count  = 0;
    int unsigned result_count = 0;
    int unsigned cycle_count  = 0;

    // Random walk of the stimulus clock, tank level and sensor health.
    logic [31:0] clock_ms   = '0;
    bit          tank_state = 1'b0;
    bit          good_state = 1'b1;

    dir_row_t dir_rows[$];

    always #5 clk = ~clk;

    function automatic logic [31:0] since(input logic [31:0] now, input logic [31:0] mark);
        return now - mark;
    endfunction

    // One step of the supervisor. A user command only sends a nonzero code and may
    // clear the lock. A tick tracks the tank first; while the sensors are off
    // it only waits out the off time, otherwise it polls, raises the alarm,
    // forces the toggle once, or starts a sensor power cycle.
    function automatic result_t supervise_step(input item_t it);
        result_t r;
        int      drop;
        int      limit;
        r = '0;
        limit = int'(cur_cfg.temp_drop_threshold);
        if (it.cmd)
        begin
            if (it.user_code != 32'd0)
            begin
                if (it.user_code == cur_cfg.toggle_code)
                    toggle_lock = 1'b0;
                r.ir_send = 1'b1;
                r.ir_code = it.user_code;
            end
        end
        else
        begin
            if (!it.tank_full)
            begin
                tank_clear_ms = it.now_ms;
                if (alarm_on)
                begin
                    alarm_on = 1'b0;
                    r.alarm_stop = 1'b1;
                end
            end
            if (!sensors_down)
            begin
                if (since(it.now_ms, poll_ms) > cur_cfg.poll_interval_ms)
                begin
                    poll_ms = it.now_ms;
                    if (it.sample_valid)
                    begin
                        held_before  = it.temp_before;
                        held_after   = it.temp_after;
                        sample_stale = 1'b0;
                    end
                    else
                        sample_stale = 1'b1;
                end
                if (!sample_stale)
                begin
                    // The drop is taken at full precision, so it can reach +/-65535.
                    drop = int'(held_before) - int'(held_after);
                    good_ms = it.now_ms;
                    if (drop > limit && it.tank_full)
                    begin
                        if (!alarm_on)
                        begin
                            alarm_on = 1'b1;
                            r.alarm_start = 1'b1;
                        end
                        else if (since(it.now_ms, tank_clear_ms) > cur_cfg.water_full_limit_ms)
                        begin
                            if (!toggle_lock)
                            begin
                                r.ir_send = 1'b1;
                                r.ir_code = cur_cfg.toggle_code;
                            end
                            toggle_lock = 1'b1;
                        end
                    end
                end
                else if (since(it.now_ms, good_ms) > cur_cfg.sensor_offline_limit_ms)
                begin
                    r.sensor_power_off = 1'b1;
                    sensors_down = 1'b1;
                    power_off_ms = it.now_ms;
                end
            end
            else if (since(it.now_ms, power_off_ms) > cur_cfg.sensor_off_duration_ms)
            begin
                r.sensor_power_on = 1'b1;
                sensors_down = 1'b0;
            end
        end
        r.auto_toggle_locked = toggle_lock;
        r.alarm_active = alarm_on;
        return r;
    endfunction

    function automatic item_t tick_beat(input logic [31:0] now, input bit full, input bit good,
                                        input logic signed [15:0] before_t,
                                        input logic signed [15:0] after_t);
        item_t it;
        it = '0;
        it.now_ms       = now;
        it.tank_full    = full;
        it.sample_valid = good;
        it.temp_before  = before_t;
        it.temp_after   = after_t;
        return it;
    endfunction

    function automatic item_t remote_beat(input logic [31:0] code);
        item_t it;
        it = '0;
        it.cmd       = 1'b1;
        it.user_code = code;
        return it;
    endfunction

    // Random item. Most ticks move the clock forward by a bounded step and follow
    // slow random walks of the tank and sensor health, so that alarms, forced
    // toggles and sensor power cycles all happen. Half of the ticks put the
    // temperature drop within one of the threshold. A few ticks jump to any time.
    function automatic item_t rand_item(input logic [31:0] step_hi);
        item_t       it;
        logic [31:0] raw;
        int unsigned pick;
        int          after_i;
        int          drop_i;
        raw = $urandom;
        it.cmd          = 1'b0;
        it.now_ms       = $urandom;
        it.tank_full    = raw[0];
        it.sample_valid = raw[1];
        it.temp_before  = raw[15:0];
        it.temp_after   = raw[31:16];
        it.user_code    = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            it.cmd = 1'b1;
            case ($urandom_range(0, 2))
                0: it.user_code = 32'd0;
                1: it.user_code = cur_cfg.toggle_code;
                default: ;
            endcase
        end
        else
        begin
            if (pick >= 12)
                it.now_ms = clock_ms + $urandom_range(0, step_hi);
            clock_ms = it.now_ms;
            if ($urandom_range(0, 99) < 6)
                tank_state = !tank_state;
            if ($urandom_range(0, 99) < 5)
                good_state = !good_state;
            it.tank_full    = tank_state;
            it.sample_valid = ($urandom_range(0, 19) == 0) ? !good_state : good_state;
            if ($urandom_range(0, 1) == 1)
            begin
                drop_i  = int'(cur_cfg.temp_drop_threshold) + int'($urandom_range(0, 2)) - 1;
                after_i = int'($urandom_range(0, 20000)) - 20000;
                it.temp_after  = 16'(after_i);
                it.temp_before = 16'(after_i + drop_i);
            end
        end
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < PRINT_LIMIT)
            $display("mismatch on result %0d: %s got %h want %h", result_count, what, got, want);
        error_count++;
    endtask

    task automatic compare_outcome(input result_t got);
        result_t want;
        if (pending_outcomes.size() == 0)
        begin
            report_mismatch("result beat with nothing owed, ir_code", got.ir_code, 32'd0);
        end
        else
        begin
            want = pending_outcomes.pop_front();
            if (got.ir_send !== want.ir_send)
                report_mismatch("ir_send", 32'(got.ir_send), 32'(want.ir_send));
            if (got.ir_code !== want.ir_code)
                report_mismatch("ir_code", got.ir_code, want.ir_code);
            if (got.alarm_start !== want.alarm_start)
                report_mismatch("alarm_start", 32'(got.alarm_start), 32'(want.alarm_start));
            if (got.alarm_stop !== want.alarm_stop)
                report_mismatch("alarm_stop", 32'(got.alarm_stop), 32'(want.alarm_stop));
            if (got.sensor_power_off !== want.sensor_power_off)
                report_mismatch("sensor_power_off", 32'(got.sensor_power_off),
                                32'(want.sensor_power_off));
            if (got.sensor_power_on !== want.sensor_power_on)
                report_mismatch("sensor_power_on", 32'(got.sensor_power_on),
                                32'(want.sensor_power_on));
            if (got.auto_toggle_locked !== want.auto_toggle_locked)
                report_mismatch("auto_toggle_locked", 32'(got.auto_toggle_locked),
                                32'(want.auto_toggle_locked));
            if (got.alarm_active !== want.alarm_active)
                report_mismatch("alarm_active", 32'(got.alarm_active), 32'(want.alarm_active));
        end
        result_count++;
    endtask

    // Offers one item after a random gap, none in steady stretches, and waits for
    // its beat. The outcome is worked out at acceptance; a typed-in outcome replaces it when given.
    task automatic offer_item(input item_t it, input bit typed, input result_t want);
        int unsigned gap;
        result_t     predicted;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_if.valid   <= 1'b1;
        item_if.payload <= it;
        do @(posedge clk); while (!item_if.ready);
        predicted = supervise_step(it);
        pending_outcomes.push_back(typed ? want : predicted);
    endtask

    task automatic add_row(input item_t it, input bit typed, input result_t want);
        dir_row_t row;
        row.stim  = it;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    // Leaves valid high between writes; the caller lowers it after the last one.
    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] index, input logic [31:0] data);
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= cfg_beat_t'{index: index, data: data};
        do @(posedge clk); while (!cfg_if.ready);
        case (index)
            CFG_POLL_INTERVAL:  cur_cfg.poll_interval_ms        = data;
            CFG_WATER_FULL_LIM: cur_cfg.water_full_limit_ms     = data;
            CFG_OFFLINE_LIM:    cur_cfg.sensor_offline_limit_ms = data;
            CFG_OFF_DURATION:   cur_cfg.sensor_off_duration_ms  = data;
            CFG_TEMP_DROP_THR:  cur_cfg.temp_drop_threshold     = data[THRESH_WIDTH-1:0];
            CFG_TOGGLE_CODE:    cur_cfg.toggle_code             = data;
            default: ;
        endcase
    endtask

    // Writes every register, then the unused indexes with random data.
    task automatic load_config(input logic [31:0] poll, input logic [31:0] water,
                               input logic [31:0] offline, input logic [31:0] off_dur,
                               input logic [31:0] thr_word, input logic [31:0] code);
        write_reg(CFG_POLL_INTERVAL, poll);
        write_reg(CFG_WATER_FULL_LIM, water);
        write_reg(CFG_OFFLINE_LIM, offline);
        write_reg(CFG_OFF_DURATION, off_dur);
        write_reg(CFG_TEMP_DROP_THR, thr_word);
        write_reg(CFG_TOGGLE_CODE, code);
        for (int k = int'(CFG_SPARE_FIRST); k < (1 << CFG_INDEX_WIDTH); k++)
            write_reg(CFG_INDEX_WIDTH'(k), $urandom);
        cfg_if.valid <= 1'b0;
    endtask

    // Waits until the block owes nothing, so that registers may be written.
    task automatic settle();
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // A run of random items. With pressure set, the result side is held off for
    // a long stretch a third of the way in, and the driver drains the block
    // completely two thirds of the way in, with the item side idle meanwhile.
    task automatic run_random(input int count, input logic [31:0] step_hi, input bit pressure);
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (pressure && i == count / 3)
                hold_req = 1'b1;
            if (pressure && i == (2 * count) / 3)
            begin
                item_if.valid <= 1'b0;
                settle();
            end
            offer_item(rand_item(step_hi), 1'b0, QUIET);
        end
        item_if.valid <= 1'b0;
    endtask

    // Every input starts at a known value; reset is held from time zero and released once.
    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        item_if.valid     = 1'b0;
        item_if.payload   = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.payload    = '0;
        result_if.ready   = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Result taker. It stalls for a random gap before each beat, not at all in
    // steady stretches, and once holds off long enough for the block to fill up
    // and push back on the item side.
    initial
    begin : take_results
        int unsigned gap;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = steady ? 0 : $urandom_range(0, 3);
            if (gap != 0)
            begin
                result_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            do @(posedge clk); while (!result_if.valid);
            compare_outcome(result_if.payload);
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        item_t b;

        // Directed part, at the reset register values. Outcomes are typed in
        // where they follow directly from reset or from the extremes.
        add_row(tick_beat(32'd0, 1'b0, 1'b1, 16'sd400, 16'sd300), 1'b1, QUIET);
        add_row(remote_beat(32'd0), 1'b1, QUIET);
        add_row(remote_beat(32'hFFFF_FFFF), 1'b1,
                '{ir_send: 1'b1, ir_code: 32'hFFFF_FFFF, default: '0});
        // Largest positive drop with the tank full; the user code on a tick is ignored.
        b = tick_beat(32'd2001, 1'b1, 1'b1, 16'sh7FFF, 16'sh8000);
        b.user_code = 32'hFFFF_FFFF;
        add_row(b, 1'b1, '{alarm_start: 1'b1, alarm_active: 1'b1, default: '0});
        add_row(tick_beat(32'd2002, 1'b1, 1'b1, 16'sd0, 16'sd0), 1'b0, QUIET);
        // Largest negative drop; the alarm stays on since the tank is still full.
        add_row(tick_beat(32'd62001, 1'b1, 1'b1, 16'sh8000, 16'sh7FFF), 1'b0, QUIET);
        // Tank full past the limit with the drop one above the threshold: forced toggle.
        add_row(tick_beat(32'd64002, 1'b1, 1'b1, 16'sd100, 16'sd51), 1'b1,
                '{ir_send: 1'b1, ir_code: RST_TOGGLE_CODE, auto_toggle_locked: 1'b1,
                  alarm_active: 1'b1, default: '0});
        // Drop equal to the threshold does not count.
        add_row(tick_beat(32'd66003, 1'b1, 1'b1, 16'sd100, 16'sd52), 1'b0, QUIET);
        // The toggle code from the user clears the lock.
        add_row(remote_beat(RST_TOGGLE_CODE), 1'b1,
                '{ir_send: 1'b1, ir_code: RST_TOGGLE_CODE, alarm_active: 1'b1, default: '0});
        add_row(tick_beat(32'd66004, 1'b0, 1'b1, 16'sd0, 16'sd0), 1'b0, QUIET);
        // Invalid samples until the sensors go offline and get power cycled.
        add_row(tick_beat(32'd68005, 1'b0, 1'b0, 16'sd7, -16'sd7), 1'b0, QUIET);
        add_row(tick_beat(32'd100000, 1'b0, 1'b0, 16'sd7, -16'sd7), 1'b0, QUIET);
        add_row(tick_beat(32'd100001, 1'b1, 1'b1, 16'sd900, 16'sd0), 1'b0, QUIET);
        add_row(remote_beat(32'h1234_5678), 1'b0, QUIET);
        add_row(tick_beat(32'd105002, 1'b0, 1'b1, 16'sd0, 16'sd0), 1'b0, QUIET);
        add_row(tick_beat(32'd107003, 1'b0, 1'b1, 16'sd200, 16'sd100), 1'b0, QUIET);
        // Time wraps around the top of the counter.
        add_row(tick_beat(32'hFFFF_FF00, 1'b0, 1'b1, 16'sd0, 16'sd0), 1'b0, QUIET);
        add_row(tick_beat(32'h0000_0700, 1'b1, 1'b1, 16'sd148, 16'sd100), 1'b0, QUIET);
        add_row(tick_beat(32'h0000_0F01, 1'b1, 1'b1, 16'sd149, 16'sd100), 1'b0, QUIET);
        add_row(remote_beat(32'h0000_0001), 1'b0, QUIET);
        add_row(tick_beat(32'h0000_0F02, 1'b1, 1'b0, 16'sh7FFF, 16'sh7FFF), 1'b0, QUIET);

        wait (rst_n === 1'b1);
        foreach (dir_rows[i])
            offer_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

        // Random part, still at the reset values.
        run_random(300, 32'd4000, 1'b0);

        // Short limits so that alarms, toggles and power cycles come often.
        settle();
        load_config(32'd10, 32'd100, 32'd50, 32'd20, 32'd48, $urandom);
        run_random(600, 32'd40, 1'b1);

        // All zero: every time compare passes as soon as the clock moves.
        settle();
        load_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        run_random(250, 32'd3, 1'b0);

        // All ones: no time compare can pass; the threshold keeps only its low bits.
        settle();
        load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random(200, 32'd1000000, 1'b0);

        // Moderate random settings.
        settle();
        load_config($urandom_range(0, 500), $urandom_range(0, 5000), $urandom_range(0, 3000),
                    $urandom_range(0, 1000), $urandom, $urandom);
        run_random(400, 32'd300, 1'b0);

        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_outcomes.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ccas_pkg.sv
rtl/ccas_stream_if.sv
rtl/ccas_cfg_regs.sv
rtl/ccas_ctrl.sv
rtl/cooler_condensate_alarm_supervisor_core.sv
sim/cooler_condensate_alarm_supervisor_core_tb.sv
